>>> design/afrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package afrc_pkg;

  localparam logic [7:0]  MaxFrame = 8'd64;
  localparam logic [7:0]  MinFrame = 8'd4;
  localparam logic [15:0] CrcInit  = 16'hFFFF;
  localparam logic [15:0] CrcPoly  = 16'hA001;
  localparam int unsigned CfgIdxW  = 8;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_ADDR = 2'd1,
    PH_FUNC = 2'd2,
    PH_BODY = 2'd3
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_NODE_ADDRESS = 8'd0,
    REG_NINTH_BIT_EN = 8'd1
  } cfg_reg_e;

  typedef struct packed {
    phase_e      phase;
    logic [15:0] crc;
    logic [7:0]  held0;
    logic [7:0]  held1;
    logic [7:0]  count;
    logic [7:0]  length;
    logic [7:0]  func;
  } state_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic [7:0] byte_index;
    logic       frame_ok;
    logic       frame_bad;
    logic       bad_length;
    logic [7:0] function_code;
    logic [7:0] frame_length;
    logic       addr_filter_on;
    logic [1:0] receiver_state;
  } result_t;

  function automatic logic [15:0] crc_feed(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CrcPoly;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  function automatic state_t hunt_state();
    state_t r;
    r.phase  = PH_HUNT;
    r.crc    = CrcInit;
    r.held0  = 8'h00;
    r.held1  = 8'h00;
    r.count  = 8'h00;
    r.length = 8'h00;
    r.func   = 8'h00;
    return r;
  endfunction

  // The byte leaving the two-byte hold enters the CRC once two bytes are held.
  function automatic state_t take_byte(state_t s, logic [7:0] b);
    state_t r;
    r = s;
    if (s.count >= 8'd2) begin
      r.crc = crc_feed(s.crc, s.held0);
    end
    r.held0 = s.held1;
    r.held1 = b;
    r.count = s.count + 8'd1;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/afrc_step.sv
`timescale 1ns / 1ps
`default_nettype none

module afrc_step (
  input  afrc_pkg::state_t  state_q_i,
  input  logic [7:0]        node_address_i,
  input  logic              nb_check_en_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              ninth_bit_i,
  output afrc_pkg::state_t  state_d_o,
  output afrc_pkg::result_t result_o
);
  import afrc_pkg::*;

  state_t     st;
  logic       valid;
  logic [7:0] idx;
  logic       ok;
  logic       bad;
  logic       badlen;
  logic       finish;
  logic [7:0] fcode;
  logic [7:0] flen;

  always_comb begin
    st     = state_q_i;
    valid  = 1'b0;
    idx    = 8'h00;
    ok     = 1'b0;
    bad    = 1'b0;
    badlen = 1'b0;
    finish = 1'b0;

    if (nb_check_en_i && ninth_bit_i && (st.phase != PH_HUNT)) begin
      st = hunt_state();
    end

    unique case (st.phase)
      PH_HUNT: begin
        if (rx_byte_i == node_address_i) begin
          st       = take_byte(hunt_state(), rx_byte_i);
          st.phase = PH_ADDR;
          valid    = 1'b1;
        end
      end
      PH_ADDR: begin
        idx      = st.count;
        st       = take_byte(st, rx_byte_i);
        st.func  = rx_byte_i;
        st.phase = PH_FUNC;
        valid    = 1'b1;
      end
      PH_FUNC: begin
        idx       = st.count;
        st        = take_byte(st, rx_byte_i);
        st.length = rx_byte_i;
        valid     = 1'b1;
        if ((rx_byte_i < MinFrame) || (rx_byte_i > MaxFrame)) begin
          bad    = 1'b1;
          badlen = 1'b1;
          finish = 1'b1;
        end else begin
          st.phase = PH_BODY;
        end
      end
      PH_BODY: begin
        idx   = st.count;
        st    = take_byte(st, rx_byte_i);
        valid = 1'b1;
        if (st.count >= st.length) begin
          if ((st.held0 == st.crc[7:0]) && (st.held1 == st.crc[15:8])) begin
            ok = 1'b1;
          end else begin
            bad = 1'b1;
          end
          finish = 1'b1;
        end
      end
    endcase

    fcode = st.func;
    flen  = st.length;
    if (finish) begin
      st = hunt_state();
    end
    if ((st.phase == PH_HUNT) && !finish) begin
      fcode = 8'h00;
      flen  = 8'h00;
    end
  end

  assign state_d_o = st;

  assign result_o.payload_byte   = valid ? rx_byte_i : 8'h00;
  assign result_o.payload_valid  = valid;
  assign result_o.byte_index     = valid ? idx : 8'h00;
  assign result_o.frame_ok       = ok;
  assign result_o.frame_bad      = bad;
  assign result_o.bad_length     = badlen;
  assign result_o.function_code  = fcode;
  assign result_o.frame_length   = flen;
  assign result_o.addr_filter_on = (st.phase == PH_HUNT);
  assign result_o.receiver_state = st.phase;

endmodule

`default_nettype wire

>>> design/addressed_frame_receiver_crc16_core.sv
`timescale 1ns / 1ps
`default_nettype none
// The byte-wide CRC update is one combinational step, and each accepted byte's result
// is registered. Throughput: one byte per cycle while in_stall_o is low.
// A two-entry output buffer keeps input acceptance going while one result is stalled.
// Reset (asynchronous, active low) returns to address hunting with the CRC at 0xFFFF,
// clears the configuration registers and empties the output buffer.

module addressed_frame_receiver_crc16_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    rx_byte_i,
  input  logic                          ninth_bit_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    payload_byte_o,
  output logic                          payload_valid_o,
  output logic [7:0]                    byte_index_o,
  output logic                          frame_ok_o,
  output logic                          frame_bad_o,
  output logic                          bad_length_o,
  output logic [7:0]                    function_code_o,
  output logic [7:0]                    frame_length_o,
  output logic                          addr_filter_on_o,
  output logic [1:0]                    receiver_state_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [afrc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [7:0]                    cfg_data_i
);
  import afrc_pkg::*;

  state_t     state_q;
  state_t     state_d;
  result_t    result_d;
  result_t    out_q;
  result_t    skid_q;
  logic       out_valid_q;
  logic       skid_valid_q;
  logic [7:0] node_address_q;
  logic       nb_check_en_q;
  logic       accept;
  logic       pop;

  afrc_step u_step (
    .state_q_i      (state_q),
    .node_address_i (node_address_q),
    .nb_check_en_i  (nb_check_en_q),
    .rx_byte_i      (rx_byte_i),
    .ninth_bit_i    (ninth_bit_i),
    .state_d_o      (state_d),
    .result_o       (result_d)
  );

  assign in_stall_o  = skid_valid_q;
  assign accept      = in_valid_i && !skid_valid_q;
  assign pop         = out_valid_q && !out_stall_i;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_address_q <= 8'h00;
      nb_check_en_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_NODE_ADDRESS: node_address_q <= cfg_data_i;
        REG_NINTH_BIT_EN: nb_check_en_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hunt_state();
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= accept;
        end
      end else if (accept) begin
        if (!out_valid_q) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= result_d;
      end
    end else if (accept) begin
      if (!out_valid_q) begin
        out_q <= result_d;
      end else begin
        skid_q <= result_d;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign payload_byte_o   = out_q.payload_byte;
  assign payload_valid_o  = out_q.payload_valid;
  assign byte_index_o     = out_q.byte_index;
  assign frame_ok_o       = out_q.frame_ok;
  assign frame_bad_o      = out_q.frame_bad;
  assign bad_length_o     = out_q.bad_length;
  assign function_code_o  = out_q.function_code;
  assign frame_length_o   = out_q.frame_length;
  assign addr_filter_on_o = out_q.addr_filter_on;
  assign receiver_state_o = out_q.receiver_state;

endmodule

`default_nettype wire

>>> design/afrc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module afrc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       payload_valid_o,
  input logic       frame_ok_o,
  input logic       frame_bad_o,
  input logic       bad_length_o,
  input logic       addr_filter_on_o,
  input logic [1:0] receiver_state_o
);
  import afrc_pkg::*;

  // A stalled transaction stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  a_ok_bad_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(frame_ok_o && frame_bad_o))
    else $error("frame flagged both good and bad");

  a_badlen_is_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_length_o |-> frame_bad_o && payload_valid_o)
    else $error("length abort without bad frame flag");

  // Every frame end returns the receiver to hunting.
  a_end_hunts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frame_ok_o || frame_bad_o) |->
      addr_filter_on_o && (receiver_state_o == PH_HUNT))
    else $error("receiver not hunting after frame end");

  a_filter_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (addr_filter_on_o == (receiver_state_o == PH_HUNT)))
    else $error("address filter flag disagrees with receiver state");

endmodule

bind addressed_frame_receiver_crc16_core afrc_checker u_afrc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .payload_valid_o  (payload_valid_o),
  .frame_ok_o       (frame_ok_o),
  .frame_bad_o      (frame_bad_o),
  .bad_length_o     (bad_length_o),
  .addr_filter_on_o (addr_filter_on_o),
  .receiver_state_o (receiver_state_o)
);

`default_nettype wire

>>> verif/addressed_frame_receiver_crc16_core_test.sv
`timescale 1ns / 1ps

module addressed_frame_receiver_crc16_core_test;
  import afrc_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       marker;
  } line_byte_t;

  localparam int StuckLimit = 2000;
  localparam int SqueezeCycles = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       ninth_bit = 1'b0;

  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] payload_byte;
  logic       payload_valid;
  logic [7:0] byte_index;
  logic       frame_ok;
  logic       frame_bad;
  logic       bad_length;
  logic [7:0] function_code;
  logic [7:0] frame_length;
  logic       addr_filter_on;
  logic [1:0] receiver_state;

  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  cfg_reg_e   cfg_index = REG_NODE_ADDRESS;
  logic [7:0] cfg_data = 8'h00;

  line_byte_t line_bytes[$];
  result_t    pending_echoes[$];
  int         echo_errors = 0;
  int         stuck_cycles = 0;
  int         cycle_no = 0;
  int         hold_left = 0;
  logic       squeeze_req = 1'b0;
  logic       squeeze_done = 1'b0;
  logic       calm;

  // Receiver-side copy of the configuration and the deframing state.
  logic [7:0]  my_addr = 8'h00;
  logic        marker_en = 1'b0;
  phase_e      rx_ph = PH_HUNT;
  logic [15:0] crc_run = CrcInit;
  logic [7:0]  hold_lo = 8'h00;
  logic [7:0]  hold_hi = 8'h00;
  logic [7:0]  taken_cnt = 8'h00;
  logic [7:0]  len_decl = 8'h00;
  logic [7:0]  func_latched = 8'h00;

  addressed_frame_receiver_crc16_core uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .rx_byte_i       (rx_byte),
    .ninth_bit_i     (ninth_bit),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .payload_byte_o  (payload_byte),
    .payload_valid_o (payload_valid),
    .byte_index_o    (byte_index),
    .frame_ok_o      (frame_ok),
    .frame_bad_o     (frame_bad),
    .bad_length_o    (bad_length),
    .function_code_o (function_code),
    .frame_length_o  (frame_length),
    .addr_filter_on_o(addr_filter_on),
    .receiver_state_o(receiver_state),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  assign calm = (cycle_no % 3000) >= 2200;

  function automatic logic [15:0] crc16_byte(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    repeat (8) begin
      r = r[0] ? ({1'b0, r[15:1]} ^ CrcPoly) : {1'b0, r[15:1]};
    end
    return r;
  endfunction

  function automatic void restart_hunt();
    rx_ph = PH_HUNT;
    crc_run = CrcInit;
    hold_lo = 8'h00;
    hold_hi = 8'h00;
    taken_cnt = 8'h00;
    len_decl = 8'h00;
    func_latched = 8'h00;
  endfunction

  function automatic void shift_in(logic [7:0] b);
    if (taken_cnt >= 8'd2) begin
      crc_run = crc16_byte(crc_run, hold_lo);
    end
    hold_lo = hold_hi;
    hold_hi = b;
    taken_cnt = taken_cnt + 8'd1;
  endfunction

  function automatic result_t deframe_next(logic [7:0] rx, logic marker);
    result_t r;
    logic [7:0] idx;
    logic done;
    r = '0;
    done = 1'b0;
    if (marker_en && marker && rx_ph != PH_HUNT) begin
      restart_hunt();
    end
    idx = taken_cnt;
    case (rx_ph)
      PH_HUNT: begin
        if (rx == my_addr) begin
          restart_hunt();
          shift_in(rx);
          rx_ph = PH_ADDR;
          r.payload_valid = 1'b1;
          idx = 8'h00;
        end
      end
      PH_ADDR: begin
        shift_in(rx);
        func_latched = rx;
        rx_ph = PH_FUNC;
        r.payload_valid = 1'b1;
      end
      PH_FUNC: begin
        shift_in(rx);
        len_decl = rx;
        r.payload_valid = 1'b1;
        if (rx < MinFrame || rx > MaxFrame) begin
          r.frame_bad = 1'b1;
          r.bad_length = 1'b1;
          done = 1'b1;
        end else begin
          rx_ph = PH_BODY;
        end
      end
      default: begin
        shift_in(rx);
        r.payload_valid = 1'b1;
        if (taken_cnt >= len_decl) begin
          if ({hold_hi, hold_lo} == crc_run) begin
            r.frame_ok = 1'b1;
          end else begin
            r.frame_bad = 1'b1;
          end
          done = 1'b1;
        end
      end
    endcase
    r.function_code = func_latched;
    r.frame_length = len_decl;
    if (done) begin
      restart_hunt();
    end else if (rx_ph == PH_HUNT) begin
      r.function_code = 8'h00;
      r.frame_length = 8'h00;
    end
    r.payload_byte = r.payload_valid ? rx : 8'h00;
    r.byte_index = r.payload_valid ? idx : 8'h00;
    r.addr_filter_on = (rx_ph == PH_HUNT);
    r.receiver_state = rx_ph;
    return r;
  endfunction

  function automatic string show(result_t r);
    return {$sformatf("byte %h valid %b index %0d ok %b bad %b badlen %b ",
                      r.payload_byte, r.payload_valid, r.byte_index, r.frame_ok,
                      r.frame_bad, r.bad_length),
            $sformatf("func %h len %0d hunt %b state %0d",
                      r.function_code, r.frame_length, r.addr_filter_on,
                      r.receiver_state)};
  endfunction

  function automatic void queue_byte(logic [7:0] d, logic m);
    line_byte_t b;
    b.data = d;
    b.marker = m;
    line_bytes.push_back(b);
  endfunction

  // Builds a frame with a correct CRC, optionally corrupts the last byte, and queues
  // the first keep bytes. The address byte carries the marker, plus one at mark_at.
  function automatic void queue_frame(logic [7:0] addr, logic [7:0] len, logic good,
                                      int keep, int mark_at);
    logic [7:0] fr[$];
    logic [15:0] c;
    logic [7:0] fn;
    int n;
    n = len;
    fn = $urandom;
    if (len == MinFrame && good) begin
      for (int f = 0; f < 256; f++) begin
        if (crc16_byte(crc16_byte(CrcInit, addr), f[7:0]) % 256 == MinFrame) begin
          fn = f[7:0];
        end
      end
    end
    fr.push_back(addr);
    fr.push_back(fn);
    fr.push_back(len);
    while (fr.size() < n - 2) begin
      fr.push_back($urandom);
    end
    c = CrcInit;
    for (int i = 0; i < n - 2; i++) begin
      c = crc16_byte(c, fr[i]);
    end
    if (len == MinFrame) begin
      fr.push_back(c[15:8]);
    end else begin
      fr.push_back(c[7:0]);
      fr.push_back(c[15:8]);
    end
    if (!good && n >= MinFrame) begin
      fr[n-1] = fr[n-1] ^ 8'($urandom_range(1, 255));
    end
    for (int i = 0; i < keep && i < fr.size(); i++) begin
      queue_byte(fr[i], i == 0 || i == mark_at);
    end
  endfunction

  task automatic queue_traffic(int target);
    int counted;
    int pick;
    int n;
    int mk;
    logic [7:0] len;
    logic [7:0] other;
    counted = 0;
    @(negedge clk);
    while (counted < target) begin
      pick = $urandom_range(0, 99);
      len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(21, MaxFrame))
                                        : 8'($urandom_range(MinFrame, 20));
      mk = ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, len - 1)) : -1;
      if (pick < 65) begin
        queue_frame(my_addr, len, $urandom_range(0, 4) != 0, len, mk);
        counted += len;
      end else if (pick < 75) begin
        other = my_addr ^ 8'($urandom_range(1, 255));
        queue_frame(other, len, 1'b1, len, -1);
      end else if (pick < 83) begin
        len = $urandom_range(0, 1) ? 8'($urandom_range(0, MinFrame - 1))
                                   : 8'($urandom_range(MaxFrame + 1, 255));
        queue_frame(my_addr, len, 1'b1, 3, -1);
        counted += 3;
      end else if (pick < 92) begin
        n = $urandom_range(1, len - 1);
        queue_frame(my_addr, len, 1'b1, n, -1);
        counted += n;
      end else begin
        repeat ($urandom_range(1, 6)) begin
          queue_byte($urandom, $urandom_range(0, 1));
        end
      end
    end
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [7:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    case (idx)
      REG_NODE_ADDRESS: my_addr = data;
      REG_NINTH_BIT_EN: marker_en = data[0];
      default: ;
    endcase
  endtask

  task automatic reconfigure(logic [7:0] addr, logic [7:0] en_word);
    write_reg(REG_NODE_ADDRESS, addr);
    write_reg(REG_NINTH_BIT_EN, en_word);
  endtask

  task automatic settle();
    @(posedge clk);
    while (line_bytes.size() != 0 || in_valid || pending_echoes.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk or negedge rst_n) begin : drive_line
    line_byte_t b;
    if (!rst_n) begin
      in_valid <= 1'b0;
      rx_byte <= 8'h00;
      ninth_bit <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (line_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= 11)) begin
        b = line_bytes.pop_front();
        in_valid <= 1'b1;
        rx_byte <= b.data;
        ninth_bit <= b.marker;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (squeeze_req && !squeeze_done) begin
      out_stall <= 1'b1;
      hold_left <= SqueezeCycles;
      squeeze_done <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 11);
    end
  end

  always @(posedge clk) begin : check_echo
    result_t got;
    result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = {payload_byte, payload_valid, byte_index, frame_ok, frame_bad, bad_length,
               function_code, frame_length, addr_filter_on, receiver_state};
        if (pending_echoes.size() == 0) begin
          if (echo_errors < 10) begin
            $display("unexpected transaction: %s", show(got));
          end
          echo_errors++;
        end else begin
          want = pending_echoes.pop_front();
          if (got !== want) begin
            if (echo_errors < 10) begin
              $display("mismatch: expected %s", show(want));
              $display("          actual   %s", show(got));
            end
            echo_errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        pending_echoes.push_back(deframe_next(rx_byte, ninth_bit));
      end
    end
  end

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("addressed_frame_receiver_crc16_core_test failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    reconfigure(8'h00, 8'h00);
    @(negedge clk);
    queue_byte(8'hFF, 1'b1);
    queue_frame(8'h00, 8'd5, 1'b1, 5, -1);
    queue_frame(8'h00, 8'd3, 1'b1, 3, -1);
    queue_frame(8'h00, MinFrame, 1'b1, 4, -1);
    queue_frame(8'h00, 8'd5, 1'b1, 5, 3);
    settle();

    reconfigure(8'hFF, 8'h01);
    @(negedge clk);
    queue_frame(8'hFF, 8'd10, 1'b1, 4, -1);
    queue_frame(8'hFF, 8'd5, 1'b1, 5, -1);
    queue_frame(8'hFF, 8'd255, 1'b1, 3, -1);
    settle();
    queue_traffic(385);
    settle();

    reconfigure(8'h5A, 8'hFE);
    queue_traffic(385);
    squeeze_req = 1'b1;
    settle();

    reconfigure(8'($urandom_range(1, 254)), 8'h01 | 8'($urandom));
    queue_traffic(385);
    settle();

    reconfigure(8'h00, 8'h81);
    queue_traffic(385);
    settle();

    if (echo_errors == 0 && pending_echoes.size() == 0) begin
      $display("addressed_frame_receiver_crc16_core_test passed");
    end else begin
      $display("addressed_frame_receiver_crc16_core_test failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/afrc_pkg.sv
design/afrc_step.sv
design/addressed_frame_receiver_crc16_core.sv
design/afrc_checker.sv
verif/addressed_frame_receiver_crc16_core_test.sv
